// ===== sv/assert_macros.svh =====
// assertion macros shared by the signed decimal add/sub rtl
// no dependencies; the including module must have aclk and aresetn in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SDAS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sdas assertion failed");

// next-cycle implication, checked out of reset
`define SDAS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sdas assertion failed");

`endif

// ===== sv/sdas_pkg.sv =====
// shared types, constants and the decimal digit step for the signed decimal add/sub
// no dependencies
`timescale 1ns / 1ps

package sdas_pkg;

    localparam int DIGITS    = 16;
    localparam int NIB_W     = 4;
    localparam int DATA_W    = 64;
    localparam int LO_DIGITS = (DIGITS + 1) / 2;
    localparam int STATUS_W  = 2;

    // stream payload widths, rounded up to whole bytes
    localparam int S_TDATA_W = ((2 * DATA_W + 2) + 7) / 8 * 8;
    localparam int M_TDATA_W = ((DATA_W + 1 + STATUS_W) + 7) / 8 * 8;

    localparam logic [DATA_W-1:0] DIGIT_MASK = {DATA_W{1'b1}} >> (DATA_W - NIB_W * DIGITS);

    localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVF = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INV = 2'd2;

    // decoded operand pair, x >= y whenever sub is set
    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic              sub;
        logic              neg;
        logic              invalid;
    } sdas_op_t;

    // after the low digits are done
    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] r;
        logic              carry;
        logic              sub;
        logic              neg;
        logic              invalid;
    } sdas_mid_t;

    // raw sum with the carry out of the top digit
    typedef struct packed {
        logic [DATA_W-1:0] r;
        logic              carry;
        logic              sub;
        logic              neg;
        logic              invalid;
    } sdas_sum_t;

    typedef struct packed {
        logic [DATA_W-1:0]   digits;
        logic                neg;
        logic [STATUS_W-1:0] status;
    } sdas_res_t;

    // one decimal digit of x + y + cin, or x + (9 - y) + cin for subtraction
    // returns {carry_out, digit}
    function automatic logic [NIB_W:0] digit_step(input logic [NIB_W-1:0] xd,
                                                  input logic [NIB_W-1:0] yd,
                                                  input logic             sub,
                                                  input logic             cin);
        logic [NIB_W-1:0] ye;
        logic [NIB_W:0]   s;
        logic [NIB_W:0]   res;
        ye = sub ? (4'd9 - yd) : yd;
        s  = {1'b0, xd} + {1'b0, ye} + {{NIB_W{1'b0}}, cin};
        if (s > 5'd9) begin
            res = {1'b1, 4'(s - 5'd10)};
        end else begin
            res = {1'b0, s[NIB_W-1:0]};
        end
        return res;
    endfunction

endpackage

// ===== sv/sdas_decode.sv =====
// first stage: digit check, effective sign, magnitude compare and operand swap
// depends on sdas_pkg
`timescale 1ns / 1ps

module sdas_decode import sdas_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              mode,
    input  logic [DATA_W-1:0] a_digits,
    input  logic              a_negative,
    input  logic [DATA_W-1:0] b_digits,
    input  logic              b_negative,
    output logic              op_valid,
    input  logic              op_ready,
    output sdas_op_t          op
);

    logic     valid_reg;
    sdas_op_t op_reg;
    sdas_op_t op_next;

    logic [DATA_W-1:0] am;
    logic [DATA_W-1:0] bm;
    logic              bn;
    logic              bad;

    always_comb begin
        am  = a_digits & DIGIT_MASK;
        bm  = b_digits & DIGIT_MASK;
        bn  = b_negative ^ mode;
        bad = 1'b0;
        for (int i = 0; i < DIGITS; i++) begin
            if (am[NIB_W*i +: NIB_W] > 4'd9 || bm[NIB_W*i +: NIB_W] > 4'd9) begin
                bad = 1'b1;
            end
        end
        op_next.invalid = bad;
        if (a_negative == bn) begin
            op_next.x   = am;
            op_next.y   = bm;
            op_next.sub = 1'b0;
            op_next.neg = a_negative;
        end else if (am >= bm) begin
            op_next.x   = am;
            op_next.y   = bm;
            op_next.sub = 1'b1;
            op_next.neg = a_negative;
        end else begin
            op_next.x   = bm;
            op_next.y   = am;
            op_next.sub = 1'b1;
            op_next.neg = bn;
        end
    end

    assign in_ready = !valid_reg || op_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            op_reg <= op_next;
        end
    end

    assign op_valid = valid_reg;
    assign op       = op_reg;

endmodule

// ===== sv/sdas_adder.sv =====
// two-stage decimal ripple adder: low digits, then high digits
// subtraction runs as x + nines complement of y + 1; depends on sdas_pkg
`timescale 1ns / 1ps

module sdas_adder import sdas_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      op_valid,
    output logic      op_ready,
    input  sdas_op_t  op,
    output logic      sum_valid,
    input  logic      sum_ready,
    output sdas_sum_t sum
);

    logic      mid_valid_reg;
    sdas_mid_t mid_reg;
    sdas_mid_t mid_next;
    logic      mid_ready;

    logic      sum_valid_reg;
    sdas_sum_t sum_reg;
    sdas_sum_t sum_next;

    // low digits
    always_comb begin
        logic           c;
        logic [NIB_W:0] st;
        c                = op.sub;
        mid_next.r       = '0;
        for (int i = 0; i < LO_DIGITS; i++) begin
            st = digit_step(op.x[NIB_W*i +: NIB_W], op.y[NIB_W*i +: NIB_W], op.sub, c);
            mid_next.r[NIB_W*i +: NIB_W] = st[NIB_W-1:0];
            c = st[NIB_W];
        end
        mid_next.carry   = c;
        mid_next.x       = op.x;
        mid_next.y       = op.y;
        mid_next.sub     = op.sub;
        mid_next.neg     = op.neg;
        mid_next.invalid = op.invalid;
    end

    // high digits
    always_comb begin
        logic           c;
        logic [NIB_W:0] st;
        c          = mid_reg.carry;
        sum_next.r = mid_reg.r;
        for (int i = LO_DIGITS; i < DIGITS; i++) begin
            st = digit_step(mid_reg.x[NIB_W*i +: NIB_W], mid_reg.y[NIB_W*i +: NIB_W],
                            mid_reg.sub, c);
            sum_next.r[NIB_W*i +: NIB_W] = st[NIB_W-1:0];
            c = st[NIB_W];
        end
        sum_next.carry   = c;
        sum_next.sub     = mid_reg.sub;
        sum_next.neg     = mid_reg.neg;
        sum_next.invalid = mid_reg.invalid;
    end

    assign op_ready  = !mid_valid_reg || mid_ready;
    assign mid_ready = !sum_valid_reg || sum_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
        end else begin
            if (op_ready) begin
                mid_valid_reg <= op_valid;
            end
            if (mid_ready) begin
                sum_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (op_ready && op_valid) begin
            mid_reg <= mid_next;
        end
        if (mid_ready && mid_valid_reg) begin
            sum_reg <= sum_next;
        end
    end

    assign sum_valid = sum_valid_reg;
    assign sum       = sum_reg;

endmodule

// ===== sv/sdas_finish.sv =====
// last stage: status, zero-sign cleanup and the output register
// depends on sdas_pkg
`timescale 1ns / 1ps

module sdas_finish import sdas_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      sum_valid,
    output logic      sum_ready,
    input  sdas_sum_t sum,
    output logic      res_valid,
    input  logic      res_ready,
    output sdas_res_t res
);

    logic      valid_reg;
    sdas_res_t res_reg;
    sdas_res_t res_next;
    logic      ovf;

    always_comb begin
        // the carry out of a subtraction is the dropped tens-complement carry
        ovf = sum.carry && !sum.sub;
        if (sum.invalid) begin
            res_next.digits = '0;
            res_next.neg    = 1'b0;
            res_next.status = ST_INV;
        end else if (ovf) begin
            res_next.digits = sum.r;
            res_next.neg    = sum.neg;
            res_next.status = ST_OVF;
        end else begin
            res_next.digits = sum.r;
            res_next.neg    = sum.neg && (sum.r != '0);
            res_next.status = ST_OK;
        end
    end

    assign sum_ready = !valid_reg || res_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (sum_ready) begin
            valid_reg <= sum_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_ready && sum_valid) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

// ===== sv/signed_decimal_add_sub.sv =====
// Signed decimal add/subtract on sign-magnitude BCD operands of DIGITS digits. An operand
// pair is taken in every cycle unless back-pressure fills the stages; one stage checks
// digits, compares magnitudes and orders the operands, two stages run the decimal ripple
// carry over the low and the high half of the digits, and one stage forms status and sign.
// Every stage has its own valid bit and a stage advances whenever the one after it is free,
// so a stalled output only holds back the items behind it. Status is ok, overflow (low
// digits kept, sign of the operands) or invalid digit (zero result); an ok zero is positive.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module signed_decimal_add_sub import sdas_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // a_digits, a_negative, b_digits, b_negative, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // mode
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // sum_digits, sum_negative, status, zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic      op_valid;
    logic      op_ready;
    sdas_op_t  op;
    logic      sum_valid;
    logic      sum_ready;
    sdas_sum_t sum;
    sdas_res_t res;

    sdas_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .mode       (s_tuser),
        .a_digits   (s_tdata[DATA_W-1:0]),
        .a_negative (s_tdata[DATA_W]),
        .b_digits   (s_tdata[2*DATA_W:DATA_W+1]),
        .b_negative (s_tdata[2*DATA_W+1]),
        .op_valid   (op_valid),
        .op_ready   (op_ready),
        .op         (op)
    );

    sdas_adder u_adder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .sum       (sum)
    );

    sdas_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .sum       (sum),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    always_comb begin
        m_tdata = '0;
        m_tdata[DATA_W-1:0]                    = res.digits;
        m_tdata[DATA_W]                        = res.neg;
        m_tdata[DATA_W+STATUS_W:DATA_W+1]      = res.status;
    end

    `SDAS_ASSERT_SAME(a_inv_zero, m_tvalid && res.status == ST_INV, res.digits == '0 && !res.neg)
    `SDAS_ASSERT_SAME(a_zero_pos, m_tvalid && res.status == ST_OK && res.digits == '0, !res.neg)
    `SDAS_ASSERT_SAME(a_status_code, m_tvalid,
        res.status == ST_OK || res.status == ST_OVF || res.status == ST_INV)
    `SDAS_ASSERT_NEXT(a_sub_no_ovf, sum_valid && sum_ready && sum.sub && !sum.invalid,
        res.status == ST_OK)

endmodule

// ===== dv/sdas_checker.sv =====
// checker for the signed decimal add/sub: watches both stream channels, predicts each sum
// from the accepted operand pair and compares it with the results in order
// depends on sdas_pkg for widths, the digit mask and the status codes
`timescale 1ns / 1ps

module sdas_checker import sdas_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   fail_count,
    output int                   sums_pending
);

    sdas_res_t expected_sums[$];
    int        failures;

    // signed decimal sum of two sign-magnitude bcd operands
    function automatic sdas_res_t predict_sum(input logic              subtract,
                                              input logic [DATA_W-1:0] a_raw,
                                              input logic              a_neg,
                                              input logic [DATA_W-1:0] b_raw,
                                              input logic              b_neg_raw);
        sdas_res_t         res;
        logic [DATA_W-1:0] a, b, big, little;
        logic              b_neg;
        logic              bad;
        logic              carry;
        int                d;
        a     = a_raw & DIGIT_MASK;
        b     = b_raw & DIGIT_MASK;
        b_neg = b_neg_raw ^ subtract;
        bad   = 1'b0;
        for (int i = 0; i < DIGITS; i++) begin
            if (a[NIB_W*i +: NIB_W] > 4'd9 || b[NIB_W*i +: NIB_W] > 4'd9) begin
                bad = 1'b1;
            end
        end
        res = '0;
        if (bad) begin
            res.status = ST_INV;
            return res;
        end
        carry = 1'b0;
        if (a_neg == b_neg) begin
            for (int i = 0; i < DIGITS; i++) begin
                d = int'(a[NIB_W*i +: NIB_W]) + int'(b[NIB_W*i +: NIB_W]) + int'(carry);
                carry = (d > 9);
                if (carry) begin
                    d -= 10;
                end
                res.digits[NIB_W*i +: NIB_W] = NIB_W'(d);
            end
            res.neg    = a_neg;
            res.status = carry ? ST_OVF : ST_OK;
        end else begin
            // larger magnitude minus smaller, sign follows the larger
            if (a >= b) begin
                big = a; little = b; res.neg = a_neg;
            end else begin
                big = b; little = a; res.neg = b_neg;
            end
            for (int i = 0; i < DIGITS; i++) begin
                d = int'(big[NIB_W*i +: NIB_W]) - int'(little[NIB_W*i +: NIB_W])
                    - int'(carry);
                carry = (d < 0);
                if (carry) begin
                    d += 10;
                end
                res.digits[NIB_W*i +: NIB_W] = NIB_W'(d);
            end
            res.status = ST_OK;
        end
        if (res.status == ST_OK && res.digits == '0) begin
            res.neg = 1'b0;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        sdas_res_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.digits = m_tdata[DATA_W-1:0];
                got.neg    = m_tdata[DATA_W];
                got.status = m_tdata[DATA_W+STATUS_W:DATA_W+1];
                if (expected_sums.size() == 0) begin
                    $error("result transaction with no sum expected: %h", got);
                    failures++;
                end else begin
                    want = expected_sums.pop_front();
                    if (got.digits !== want.digits) begin
                        $error("sum_digits mismatch: expected %h, actual %h",
                               want.digits, got.digits);
                        failures++;
                    end
                    if (got.neg !== want.neg) begin
                        $error("sum_negative mismatch: expected %b, actual %b",
                               want.neg, got.neg);
                        failures++;
                    end
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        failures++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_sums.push_back(predict_sum(s_tuser,
                                                    s_tdata[DATA_W-1:0],
                                                    s_tdata[DATA_W],
                                                    s_tdata[2*DATA_W:DATA_W+1],
                                                    s_tdata[2*DATA_W+1]));
            end
        end
        fail_count   <= failures;
        sums_pending <= expected_sums.size();
    end

endmodule

// ===== dv/tb.sv =====
// testbench top for signed_decimal_add_sub: drives operand pairs with random gaps and
// result back-pressure, and gives the verdict from the checker's failure and pending counts
// depends on sdas_pkg, signed_decimal_add_sub and sdas_checker
`timescale 1ns / 1ps

module tb;
    import sdas_pkg::*;

    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_SUB = 1'b1;
    localparam logic POS      = 1'b0;
    localparam logic NEG      = 1'b1;

    localparam logic [DATA_W-1:0] MAX_BCD = 64'h9999_9999_9999_9999;

    localparam int RANDOM_PAIRS = 650;
    localparam int STALL_LIMIT  = 2000;
    localparam int LATENCY      = 4;

    typedef struct packed {
        logic              mode;
        logic [DATA_W-1:0] a;
        logic              a_neg;
        logic [DATA_W-1:0] b;
        logic              b_neg;
    } operand_pair_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int sums_pending;
    int src_gap_pct    = 0;
    int sink_stall_pct = 0;
    int stall_left     = 0;
    int idle_cycles    = 0;

    signed_decimal_add_sub dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sdas_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .sums_pending (sums_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // result back-pressure in random bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(0, 99) < sink_stall_pct) begin
            stall_left <= $urandom_range(0, 11);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [DATA_W-1:0] random_bcd(input int ndig);
        logic [DATA_W-1:0] v;
        v = '0;
        for (int i = 0; i < ndig; i++) begin
            v[NIB_W*i +: NIB_W] = NIB_W'($urandom_range(0, 9));
        end
        return v;
    endfunction

    function automatic operand_pair_t random_pair();
        operand_pair_t p;
        int            kind;
        int            pos;
        kind    = $urandom_range(0, 99);
        p.mode  = 1'($urandom);
        p.a_neg = 1'($urandom);
        p.b_neg = 1'($urandom);
        p.a     = random_bcd(($urandom_range(0, 3) == 0) ? DIGITS : $urandom_range(1, DIGITS));
        p.b     = random_bcd(($urandom_range(0, 3) == 0) ? DIGITS : $urandom_range(1, DIGITS));
        if (kind < 60) begin
            // plain well-formed operands
        end else if (kind < 72) begin
            // equal or nearly equal magnitudes exercise the compare and zero result
            p.b = p.a;
            if ($urandom_range(0, 1)) begin
                pos = $urandom_range(0, DIGITS - 1);
                p.b[NIB_W*pos +: NIB_W] = NIB_W'($urandom_range(0, 9));
            end
        end else if (kind < 82) begin
            // large magnitudes, overflow when the signs agree
            p.a = random_bcd(DIGITS);
            p.b = random_bcd(DIGITS);
            p.a[DATA_W-1 -: NIB_W] = NIB_W'($urandom_range(5, 9));
            p.b[DATA_W-1 -: NIB_W] = NIB_W'($urandom_range(5, 9));
        end else if (kind < 92) begin
            // one non-decimal nibble in one operand
            pos = $urandom_range(0, DIGITS - 1);
            if ($urandom_range(0, 1)) begin
                p.a[NIB_W*pos +: NIB_W] = NIB_W'($urandom_range(10, 15));
            end else begin
                p.b[NIB_W*pos +: NIB_W] = NIB_W'($urandom_range(10, 15));
            end
        end else begin
            p.a = {$urandom, $urandom};
            p.b = {$urandom, $urandom};
        end
        return p;
    endfunction

    task automatic send_pair(input operand_pair_t p);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({p.b_neg, p.b, p.a_neg, p.a});
        s_tuser  <= p.mode;
        do @(posedge aclk); while (!s_tready);
        if ($urandom_range(0, 99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    task automatic drain_sums();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sums_pending != 0);
    endtask

    initial begin
        operand_pair_t directed[$];
        directed.push_back(operand_pair_t'{MODE_ADD, 64'h0, POS, 64'h0, POS});
        directed.push_back(operand_pair_t'{MODE_ADD, 64'h0, NEG, 64'h0, NEG});
        directed.push_back(operand_pair_t'{MODE_SUB, 64'h0, NEG, 64'h0, POS});
        directed.push_back(operand_pair_t'{MODE_ADD, MAX_BCD, POS, 64'h1, POS});
        directed.push_back(operand_pair_t'{MODE_ADD, MAX_BCD, NEG, MAX_BCD, NEG});
        directed.push_back(operand_pair_t'{MODE_SUB, MAX_BCD, POS, MAX_BCD, NEG});
        directed.push_back(operand_pair_t'{MODE_ADD, MAX_BCD, POS, MAX_BCD, NEG});
        directed.push_back(operand_pair_t'{MODE_SUB, 64'h1234_5678, NEG, 64'h1234_5678, NEG});
        directed.push_back(operand_pair_t'{MODE_SUB, 64'h1, POS, 64'h2, POS});
        directed.push_back(operand_pair_t'{MODE_SUB, 64'h1000_0000_0000_0000, POS, 64'h1, POS});
        directed.push_back(operand_pair_t'{MODE_ADD, 64'h5, NEG, 64'h3, POS});
        directed.push_back(operand_pair_t'{MODE_ADD, 64'h3, POS, 64'h5, NEG});
        directed.push_back(operand_pair_t'{MODE_SUB, 64'h3, NEG, 64'h5, NEG});
        directed.push_back(operand_pair_t'{MODE_ADD, 64'h5, POS, 64'h5, POS});
        directed.push_back(operand_pair_t'{MODE_ADD, MAX_BCD, NEG, 64'h0, POS});
        directed.push_back(operand_pair_t'{MODE_ADD, 64'h9999_9999, POS, 64'h1, POS});
        // differ only in the lowest digit, so the compare must look past the top digits
        directed.push_back(operand_pair_t'{MODE_ADD, 64'h9876_5432_1098_7653, POS,
                                           64'h9876_5432_1098_7654, NEG});
        directed.push_back(operand_pair_t'{MODE_SUB, 64'h9876_5432_1098_7654, NEG,
                                           64'h9876_5432_1098_7653, NEG});
        // non-decimal nibbles, top of a, bottom of b, everything set
        directed.push_back(operand_pair_t'{MODE_ADD, 64'hF000_0000_0000_0000, POS, 64'h1, POS});
        directed.push_back(operand_pair_t'{MODE_SUB, 64'h1, NEG, 64'h0000_0000_0000_000A, POS});
        directed.push_back(operand_pair_t'{MODE_SUB, '1, NEG, '1, NEG});

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        src_gap_pct    = 20;
        sink_stall_pct = 20;
        foreach (directed[i]) begin
            send_pair(directed[i]);
        end
        drain_sums();

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            if (n == 250) begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
                drain_sums();
            end else if (n == 420) begin
                src_gap_pct    = 40;
                sink_stall_pct = 40;
            end else if (n == 540) begin
                // last part runs at full rate
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end
            send_pair(random_pair());
        end
        drain_sums();
        repeat (LATENCY * 4) @(posedge aclk);

        if (fail_count == 0 && sums_pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/sdas_pkg.sv
sv/sdas_decode.sv
sv/sdas_adder.sv
sv/sdas_finish.sv
sv/signed_decimal_add_sub.sv
dv/sdas_checker.sv
dv/tb.sv
